@@ src/fpdc_pkg.sv @@
// Shared constants and types of the fractional-N PLL divider calculator.
package fpdc_pkg;

  localparam int unsigned RATE_W          = 32;
  localparam int unsigned INT_W           = 7;
  localparam int unsigned FRAC_OUT_W      = 22;
  localparam int unsigned PADDR_W         = 3;
  localparam int unsigned PDATA_W         = 32;

  localparam int unsigned ND_MAX_DEF      = 127;
  localparam int unsigned FRAC_BITS_DEF   = 22;
  localparam int unsigned FRACR_MAX_DEF   = 4194303;
  localparam int unsigned RATE_BITS_DEF   = 32;
  localparam int unsigned DQ_W_DEF        = RATE_W + FRAC_BITS_DEF + 1;

  localparam logic [RATE_W-1:0] REF_RATE_RESET = 32'd12_000_000;

  // Register index as taken from paddr[2].
  localparam logic REG_REF_RATE = 1'b0;

  // Control that travels alongside each item through the pipeline.
  typedef struct packed {
    logic valid;
    logic inval;
  } fpdc_ctl_t;

endpackage

@@ src/fpdc_if.sv @@
// Request and result channel interfaces of the divider calculator.
interface fpdc_req_if;
  import fpdc_pkg::*;
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] requested_rate_hz;

  modport source (output valid, output requested_rate_hz, input ready);
  modport sink   (input valid, input requested_rate_hz, output ready);
endinterface

interface fpdc_res_if;
  import fpdc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  status;
  logic [INT_W-1:0]      integer_minus_one;
  logic [FRAC_OUT_W-1:0] fraction_word;
  logic [RATE_W-1:0]     achieved_rate_hz;

  modport source (output valid, output status, output integer_minus_one,
                  output fraction_word, output achieved_rate_hz, input ready);
  modport sink   (input valid, input status, input integer_minus_one,
                  input fraction_word, input achieved_rate_hz, output ready);
endinterface

@@ src/fpdc_div_cell.sv @@
// One restoring division cell: develops one quotient bit per item.
module fpdc_div_cell #(
  parameter int unsigned DQ_W = fpdc_pkg::DQ_W_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [fpdc_pkg::RATE_W-1:0]   ref_i,
  input  fpdc_pkg::fpdc_ctl_t           ctl_i,
  input  logic [fpdc_pkg::RATE_W-1:0]   rem_i,
  input  logic [DQ_W-1:0]               dq_i,
  output fpdc_pkg::fpdc_ctl_t           ctl_o,
  output logic [fpdc_pkg::RATE_W-1:0]   rem_o,
  output logic [DQ_W-1:0]               dq_o
);
  import fpdc_pkg::*;

  logic [RATE_W:0]   trial;
  logic [RATE_W:0]   diff;
  logic              ge;
  fpdc_ctl_t         ctl_q;
  logic [RATE_W-1:0] rem_q, rem_d;
  logic [DQ_W-1:0]   dq_q, dq_d;

  // The dividend bit leaves the top of the word and the quotient bit enters at the bottom.
  always_comb begin
    trial = {rem_i, dq_i[DQ_W-1]};
    diff  = trial - {1'b0, ref_i};
    ge    = (trial >= {1'b0, ref_i});
    rem_d = ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
    dq_d  = {dq_i[DQ_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      dq_q  <= dq_d;
    end
  end

  assign ctl_o = ctl_q;
  assign rem_o = rem_q;
  assign dq_o  = dq_q;

endmodule

@@ src/fpdc_finish.sv @@
// Rounding, range checks, achieved rate and output register.
module fpdc_finish #(
  parameter int unsigned ND_MAX    = fpdc_pkg::ND_MAX_DEF,
  parameter int unsigned FRAC_BITS = fpdc_pkg::FRAC_BITS_DEF,
  parameter int unsigned FRACR_MAX = fpdc_pkg::FRACR_MAX_DEF,
  parameter int unsigned RATE_BITS = fpdc_pkg::RATE_BITS_DEF,
  parameter int unsigned DQ_W      = fpdc_pkg::RATE_W + FRAC_BITS + 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic [fpdc_pkg::RATE_W-1:0]     ref_i,
  input  fpdc_pkg::fpdc_ctl_t             ctl_i,
  input  logic [DQ_W-1:0]                 dq_i,
  output logic                            valid_o,
  output logic                            status_o,
  output logic [fpdc_pkg::INT_W-1:0]      int_o,
  output logic [fpdc_pkg::FRAC_OUT_W-1:0] frac_o,
  output logic [fpdc_pkg::RATE_W-1:0]     rate_o
);
  import fpdc_pkg::*;

  localparam int unsigned FRAC_W = FRAC_BITS + 1;
  localparam int unsigned QN_W   = $clog2(ND_MAX + 2);
  localparam int unsigned PI_W   = RATE_W + QN_W;
  localparam int unsigned PF_W   = RATE_W + FRAC_W;
  localparam int unsigned PART_W = PF_W + 1 - FRAC_BITS;
  localparam int unsigned TOT_W  = ((PI_W > PART_W) ? PI_W : PART_W) + 1;
  localparam int unsigned ND_OW  = (QN_W > INT_W) ? QN_W : INT_W;
  localparam int unsigned FR_OW  = (FRAC_W > FRAC_OUT_W) ? FRAC_W : FRAC_OUT_W;
  localparam logic [PF_W:0] HALF = (PF_W + 1)'(1) << (FRAC_BITS - 1);
  localparam logic [63:0] LIM = (RATE_BITS < 32) ? ((64'd1 << RATE_BITS) - 64'd1)
                                                 : 64'h0000_0000_FFFF_FFFF;

  // Stage A: round the fraction and check ranges.
  logic [RATE_W-1:0] quot_a;
  logic [FRAC_W-1:0] f2_a;
  logic [FRAC_W:0]   fsum_a;
  logic [FRAC_W-1:0] frac_a;
  fpdc_ctl_t         ctl_a;
  fpdc_ctl_t         a_ctl_q;
  logic [QN_W-1:0]   a_quot_q;
  logic [FRAC_W-1:0] a_frac_q;

  always_comb begin
    quot_a = dq_i[DQ_W-1 -: RATE_W];
    f2_a   = dq_i[FRAC_W-1:0];
    // The extra quotient bit gives a round-to-nearest with half rounding up.
    fsum_a = {1'b0, f2_a} + (FRAC_W + 1)'(1);
    frac_a = fsum_a[FRAC_W:1];
    ctl_a.valid = ctl_i.valid;
    ctl_a.inval = ctl_i.inval || (quot_a == '0) ||
                  (quot_a > RATE_W'(ND_MAX + 1)) ||
                  (RATE_W'(frac_a) > RATE_W'(FRACR_MAX));
  end

  // Stage B: the two products.
  fpdc_ctl_t         b_ctl_q;
  logic [PI_W-1:0]   b_pi_q;
  logic [PF_W-1:0]   b_pf_q;
  logic [QN_W-1:0]   b_nd_q;
  logic [FRAC_W-1:0] b_frac_q;

  // Stage C: rounding of the fractional part, sum and saturation.
  logic [PF_W:0]      part_sum;
  logic [PART_W-1:0]  part;
  logic [TOT_W-1:0]   total;
  logic [ND_OW-1:0]   nd_ext;
  logic [FR_OW-1:0]   fr_ext;
  logic               valid_q;
  logic               status_q, status_d;
  logic [INT_W-1:0]   int_q, int_d;
  logic [FRAC_OUT_W-1:0] frac_q, frac_d;
  logic [RATE_W-1:0]  rate_q, rate_d;

  always_comb begin
    part_sum = (PF_W + 1)'(b_pf_q) + HALF;
    part     = part_sum[PF_W:FRAC_BITS];
    total    = TOT_W'(b_pi_q) + TOT_W'(part);
    nd_ext   = ND_OW'(b_nd_q);
    fr_ext   = FR_OW'(b_frac_q);
    status_d = b_ctl_q.inval;
    if (b_ctl_q.inval) begin
      int_d  = '0;
      frac_d = '0;
      rate_d = '0;
    end else begin
      int_d  = nd_ext[INT_W-1:0];
      frac_d = fr_ext[FRAC_OUT_W-1:0];
      rate_d = (64'(total) > LIM) ? LIM[RATE_W-1:0] : total[RATE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_ctl_q <= '0;
      b_ctl_q <= '0;
      valid_q <= 1'b0;
    end else if (en_i) begin
      a_ctl_q <= ctl_a;
      b_ctl_q <= a_ctl_q;
      valid_q <= b_ctl_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_quot_q <= quot_a[QN_W-1:0];
      a_frac_q <= frac_a;
      b_pi_q   <= PI_W'(ref_i) * PI_W'(a_quot_q);
      b_pf_q   <= PF_W'(ref_i) * PF_W'(a_frac_q);
      b_nd_q   <= a_quot_q - QN_W'(1);
      b_frac_q <= a_frac_q;
      status_q <= status_d;
      int_q    <= int_d;
      frac_q   <= frac_d;
      rate_q   <= rate_d;
    end
  end

  assign valid_o  = valid_q;
  assign status_o = status_q;
  assign int_o    = int_q;
  assign frac_o   = frac_q;
  assign rate_o   = rate_q;

endmodule

@@ src/frac_pll_divider_calc.sv @@
// Top level of the fractional-N PLL divider calculator.
// The block accepts one requested rate per cycle while no finished result
// waits at the output, and returns, for each, the integer and fractional PLL
// settings and the achieved rate, in request order. Each transaction passes
// through a chain of restoring division cells (one quotient bit per cell; 55
// cells with the default parameters) and then finishing stages A, B and C,
// sustaining one transaction per cycle while results are drained. The whole
// pipeline advances together: while a finished result waits at the output,
// no stage moves and the request channel is not ready. The reference rate
// register sits at byte address 0 of the APB port and resets to 12 MHz; it
// may be written only while no transaction is in flight, since every cell
// divides by its live value.
module frac_pll_divider_calc #(
  parameter int unsigned ND_MAX    = fpdc_pkg::ND_MAX_DEF,
  parameter int unsigned FRAC_BITS = fpdc_pkg::FRAC_BITS_DEF,
  parameter int unsigned FRACR_MAX = fpdc_pkg::FRACR_MAX_DEF,
  parameter int unsigned RATE_BITS = fpdc_pkg::RATE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fpdc_req_if.sink                      req,
  fpdc_res_if.source                    res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fpdc_pkg::PADDR_W-1:0]  paddr,
  input  logic [fpdc_pkg::PDATA_W-1:0]  pwdata,
  output logic [fpdc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import fpdc_pkg::*;

  // Dividend word: the requested rate followed by FRAC_BITS + 1 zero bits.
  // The extra bit lets the finishing stage round the fraction to nearest.
  localparam int unsigned FRAC_W = FRAC_BITS + 1;
  localparam int unsigned DQ_W   = RATE_W + FRAC_W;

  logic [RATE_W-1:0] ref_q;
  logic              adv;
  logic              res_valid;

  // Reference rate register. Writes land on the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= REF_RATE_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_REF_RATE)) begin
      ref_q <= pwdata[RATE_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_REF_RATE) ? PDATA_W'(ref_q) : '0;

  // The pipeline moves whenever the output register is empty or being drained.
  assign adv       = !res_valid || res.ready;
  assign req.ready = adv;

  fpdc_ctl_t         ctl_c [DQ_W+1];
  logic [RATE_W-1:0] rem_c [DQ_W+1];
  logic [DQ_W-1:0]   dq_c  [DQ_W+1];

  // A zero request or a zero reference is marked invalid on entry; the cells
  // still run but their quotient is then ignored.
  always_comb begin
    ctl_c[0].valid = req.valid;
    ctl_c[0].inval = (req.requested_rate_hz == '0) || (ref_q == '0);
    rem_c[0]       = '0;
    dq_c[0]        = {req.requested_rate_hz, FRAC_W'(0)};
  end

  for (genvar g = 0; g < DQ_W; g++) begin : g_cell
    fpdc_div_cell #(
      .DQ_W (DQ_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .ref_i  (ref_q),
      .ctl_i  (ctl_c[g]),
      .rem_i  (rem_c[g]),
      .dq_i   (dq_c[g]),
      .ctl_o  (ctl_c[g+1]),
      .rem_o  (rem_c[g+1]),
      .dq_o   (dq_c[g+1])
    );
  end

  // After the last cell the upper bits hold the integer quotient and the
  // lower FRAC_BITS + 1 bits the doubled fraction; the final remainder is
  // not needed.
  fpdc_finish #(
    .ND_MAX    (ND_MAX),
    .FRAC_BITS (FRAC_BITS),
    .FRACR_MAX (FRACR_MAX),
    .RATE_BITS (RATE_BITS),
    .DQ_W      (DQ_W)
  ) u_finish (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .ref_i    (ref_q),
    .ctl_i    (ctl_c[DQ_W]),
    .dq_i     (dq_c[DQ_W]),
    .valid_o  (res_valid),
    .status_o (res.status),
    .int_o    (res.integer_minus_one),
    .frac_o   (res.fraction_word),
    .rate_o   (res.achieved_rate_hz)
  );

  assign res.valid = res_valid;

endmodule

@@ src/fpdc_checker.sv @@
// Port-level checks of the divider calculator, bound to the top level.
module fpdc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            req_valid_i,
  input logic                            req_ready_i,
  input logic                            res_valid_i,
  input logic                            res_ready_i,
  input logic                            res_status_i,
  input logic [fpdc_pkg::INT_W-1:0]      res_int_i,
  input logic [fpdc_pkg::FRAC_OUT_W-1:0] res_frac_i,
  input logic [fpdc_pkg::RATE_W-1:0]     res_rate_i
);
  import fpdc_pkg::*;

  // A stalled result stays offered.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_status_i) && $stable(res_int_i) &&
                                    $stable(res_frac_i) && $stable(res_rate_i))
    else $error("result payload changed while stalled");

  // Requests are taken exactly when the output side can move.
  a_req_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_i == (!res_valid_i || res_ready_i))
    else $error("request ready does not follow output drain");

  // An invalid result carries zero settings.
  a_inval_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_status_i |-> (res_int_i == '0) && (res_frac_i == '0) &&
                                    (res_rate_i == '0))
    else $error("invalid result with non-zero settings");

  // A valid setting always yields a non-zero achieved rate.
  a_valid_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_status_i |-> (res_rate_i != '0))
    else $error("valid result with zero achieved rate");

endmodule

bind frac_pll_divider_calc fpdc_checker u_fpdc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req.valid),
  .req_ready_i  (req.ready),
  .res_valid_i  (res.valid),
  .res_ready_i  (res.ready),
  .res_status_i (res.status),
  .res_int_i    (res.integer_minus_one),
  .res_frac_i   (res.fraction_word),
  .res_rate_i   (res.achieved_rate_hz)
);
